FILE: design/fnbm_pkg.sv
// Shared constants, register codes and types for the framed name beacon modulator.
package fnbm_pkg;

   // Frame geometry
   localparam int FRAME_BITS     = 10;
   localparam int PREAMBLE_COUNT = 2;
   localparam int NAME_BYTES     = 4;

   // Field widths
   localparam int ROUTE_W     = 3;
   localparam int MODE_W      = 2;
   localparam int DIV_W       = 8;
   localparam int NAME_W      = 32;
   localparam int POS_W       = 4;
   localparam int CHAR_W      = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   // Position limits
   localparam logic [POS_W-1:0]        FRAME_END  = POS_W'(FRAME_BITS);
   localparam logic [POS_W-1:0]        LAST_BIT   = POS_W'(FRAME_BITS - 1);
   localparam logic signed [POS_W-1:0] BYTE_START = POS_W'(-PREAMBLE_COUNT);
   localparam logic signed [POS_W:0]   NAME_END   = (POS_W + 1)'(NAME_BYTES);

   // Channel route codes
   localparam logic [ROUTE_W-1:0] ROUTE_OFF   = 3'd0;
   localparam logic [ROUTE_W-1:0] ROUTE_AF    = 3'd1;
   localparam logic [ROUTE_W-1:0] ROUTE_RF    = 3'd2;
   localparam logic [ROUTE_W-1:0] ROUTE_AF_RF = 3'd3;
   localparam logic [ROUTE_W-1:0] ROUTE_RF_AF = 3'd4;

   // Pattern mode codes
   localparam logic [MODE_W-1:0] MODE_SQUARE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_NAME   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_HIGH   = 2'd2;

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_ROUTE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MODE    = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DIVIDER = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_NAME    = 2'd3;

   typedef struct packed {
      logic [ROUTE_W-1:0] route;
      logic [MODE_W-1:0]  mode;
      logic [DIV_W-1:0]   divider;
      logic [NAME_W-1:0]  name_word;
   } fnbm_cfg_type;

   typedef struct packed {
      logic af;
      logic rf;
   } fnbm_levels_type;

endpackage

FILE: design/fnbm_csr.sv
// Configuration register bank of the framed name beacon modulator.
module fnbm_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [fnbm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [fnbm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   output fnbm_pkg::fnbm_cfg_type             cfg
);

   fnbm_pkg::fnbm_cfg_type cfg_ff;
   fnbm_pkg::fnbm_cfg_type cfg_in;

   // Decode the write into the addressed field
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         case (csr_index)
            fnbm_pkg::CSR_ROUTE:   cfg_in.route     = csr_wdata[fnbm_pkg::ROUTE_W-1:0];
            fnbm_pkg::CSR_MODE:    cfg_in.mode      = csr_wdata[fnbm_pkg::MODE_W-1:0];
            fnbm_pkg::CSR_DIVIDER: cfg_in.divider   = csr_wdata[fnbm_pkg::DIV_W-1:0];
            fnbm_pkg::CSR_NAME:    cfg_in.name_word = csr_wdata[fnbm_pkg::NAME_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: design/fnbm_engine.sv
// Tick engine: pattern state, secondary divider and held output levels.
module fnbm_engine (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        step_en,
   input  logic                        tick,
   input  fnbm_pkg::fnbm_cfg_type      cfg,
   output fnbm_pkg::fnbm_levels_type   levels_next
);

   logic [fnbm_pkg::POS_W-1:0]        bit_position_ff, bit_position_in;
   logic signed [fnbm_pkg::POS_W-1:0] byte_position_ff, byte_position_in;
   logic [fnbm_pkg::CHAR_W-1:0]       char_shift_ff, char_shift_in;
   logic                              secondary_phase_ff, secondary_phase_in;
   logic [fnbm_pkg::DIV_W-1:0]        secondary_count_ff, secondary_count_in;
   logic                              af_hold_ff, af_hold_in;
   logic                              rf_hold_ff, rf_hold_in;

   logic                              active;
   logic                              dual_route;
   logic [fnbm_pkg::POS_W-1:0]        bit_inc;
   logic signed [fnbm_pkg::POS_W:0]   byte_inc;
   logic [fnbm_pkg::POS_W-1:0]        name_bit;
   logic signed [fnbm_pkg::POS_W-1:0] name_byte;
   logic                              prim_level;
   logic [fnbm_pkg::DIV_W-1:0]        count_dec;

   assign active = step_en && tick &&
                   (cfg.route == fnbm_pkg::ROUTE_AF || cfg.route == fnbm_pkg::ROUTE_RF ||
                    cfg.route == fnbm_pkg::ROUTE_AF_RF || cfg.route == fnbm_pkg::ROUTE_RF_AF);
   assign dual_route = cfg.route == fnbm_pkg::ROUTE_AF_RF ||
                       cfg.route == fnbm_pkg::ROUTE_RF_AF;

   // Advance frame positions; wrap bit count at frame end, byte count past the name
   assign bit_inc  = bit_position_ff + fnbm_pkg::POS_W'(1);
   assign byte_inc = {byte_position_ff[fnbm_pkg::POS_W-1], byte_position_ff} +
                     (fnbm_pkg::POS_W + 1)'(1);

   always_comb begin
      name_bit  = bit_inc;
      name_byte = byte_position_ff;
      if (bit_inc >= fnbm_pkg::FRAME_END) begin
         name_bit = '0;
         if (byte_inc >= fnbm_pkg::NAME_END) begin
            name_byte = fnbm_pkg::BYTE_START;
         end else begin
            name_byte = byte_inc[fnbm_pkg::POS_W-1:0];
         end
      end
   end

   // Primary pattern: square, framed name or constant high
   always_comb begin
      bit_position_in  = bit_position_ff;
      byte_position_in = byte_position_ff;
      char_shift_in    = char_shift_ff;
      prim_level       = 1'b1;
      case (cfg.mode)
         fnbm_pkg::MODE_SQUARE: begin
            prim_level      = bit_position_ff[0];
            bit_position_in = bit_position_ff ^ fnbm_pkg::POS_W'(1);
         end
         fnbm_pkg::MODE_NAME: begin
            bit_position_in  = name_bit;
            byte_position_in = name_byte;
            if (name_byte[fnbm_pkg::POS_W-1]) begin
               // preamble at mark level
               prim_level = 1'b1;
            end else if (name_bit == '0) begin
               // start bit: load the name byte
               char_shift_in = cfg.name_word[{name_byte[1:0], 3'b000} +: fnbm_pkg::CHAR_W];
               prim_level    = 1'b0;
            end else if (name_bit == fnbm_pkg::LAST_BIT) begin
               prim_level = 1'b1;
            end else begin
               prim_level    = char_shift_ff[0];
               char_shift_in = char_shift_ff >> 1;
            end
         end
         default: begin
            prim_level = 1'b1;
         end
      endcase
   end

   // Secondary divider and line routing
   assign count_dec = secondary_count_ff - fnbm_pkg::DIV_W'(1);

   always_comb begin
      secondary_count_in = secondary_count_ff;
      secondary_phase_in = secondary_phase_ff;
      af_hold_in         = af_hold_ff;
      rf_hold_in         = rf_hold_ff;
      if (cfg.route == fnbm_pkg::ROUTE_AF || cfg.route == fnbm_pkg::ROUTE_AF_RF) begin
         af_hold_in = prim_level;
      end else begin
         rf_hold_in = prim_level;
      end
      if (dual_route) begin
         secondary_count_in = count_dec;
         if (count_dec == '0) begin
            secondary_count_in = cfg.divider;
            secondary_phase_in = ~secondary_phase_ff;
            if (cfg.route == fnbm_pkg::ROUTE_AF_RF) begin
               rf_hold_in = ~secondary_phase_ff;
            end else begin
               af_hold_in = ~secondary_phase_ff;
            end
         end
      end
   end

   // Commit state only for an active tick
   always_ff @(posedge clock) begin
      if (reset) begin
         bit_position_ff    <= '0;
         byte_position_ff   <= fnbm_pkg::BYTE_START;
         char_shift_ff      <= '0;
         secondary_phase_ff <= 1'b0;
         secondary_count_ff <= '0;
         af_hold_ff         <= 1'b0;
         rf_hold_ff         <= 1'b0;
      end else if (active) begin
         bit_position_ff    <= bit_position_in;
         byte_position_ff   <= byte_position_in;
         char_shift_ff      <= char_shift_in;
         secondary_phase_ff <= secondary_phase_in;
         secondary_count_ff <= secondary_count_in;
         af_hold_ff         <= af_hold_in;
         rf_hold_ff         <= rf_hold_in;
      end
   end

   // Levels after this item
   assign levels_next.af = active ? af_hold_in : af_hold_ff;
   assign levels_next.rf = active ? rf_hold_in : rf_hold_ff;

endmodule

FILE: design/framed_name_beacon_modulator_core.sv
// Top level of the framed name beacon modulator: handshake stages around the tick engine.
//
//   channel | ports                                  | direction
//   --------+----------------------------------------+----------
//   req     | req_valid, req_stall, req_tick_advance | in
//   rsp     | rsp_valid, rsp_stall, rsp_af_level,    | out
//           | rsp_rf_level                           |
//   csr     | csr_write_en, csr_index, csr_wdata     | in
//
// One item per clock while the result is not stalled: an item is held in the input
// register, the tick engine updates its state and the levels land in the result register.
// Reset is synchronous; it holds req_stall high and clears all state but the tick and
// level data registers. A stalled result holds the input register; req_stall then rises.
module framed_name_beacon_modulator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_tick_advance,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_af_level,
   output logic                              rsp_rf_level,
   input  logic                              csr_write_en,
   input  logic [fnbm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [fnbm_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   fnbm_pkg::fnbm_cfg_type    cfg;
   fnbm_pkg::fnbm_levels_type levels_next;

   logic s1_valid_ff, s1_valid_in;
   logic s1_tick_ff, s1_tick_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_af_ff, rsp_af_in;
   logic rsp_rf_ff, rsp_rf_in;
   logic advance;
   logic req_take;

   fnbm_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cfg          (cfg)
   );

   fnbm_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .step_en     (advance),
      .tick        (s1_tick_ff),
      .cfg         (cfg),
      .levels_next (levels_next)
   );

   // Move the held item forward when the result register is free or draining
   assign advance   = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = reset || (s1_valid_ff && !advance);
   assign req_take  = req_valid && !req_stall;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      s1_tick_in  = s1_tick_ff;
      if (!req_stall) begin
         s1_valid_in = req_valid;
         s1_tick_in  = req_take ? req_tick_advance : s1_tick_ff;
      end
   end

   // Capture levels on advance; drop the result after its transfer
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_af_in    = rsp_af_ff;
      rsp_rf_in    = rsp_rf_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
         rsp_af_in    = levels_next.af;
         rsp_rf_in    = levels_next.rf;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_tick_ff <= s1_tick_in;
      rsp_af_ff  <= rsp_af_in;
      rsp_rf_ff  <= rsp_rf_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_af_level = rsp_af_ff;
   assign rsp_rf_level = rsp_rf_ff;

endmodule

FILE: design/fnbm_checker.sv
// Port-level checks for the framed name beacon modulator, bound to the top level.
module fnbm_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic                              rsp_af_level,
   input logic                              rsp_rf_level
);

   // A stalled result holds its levels
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_af_level) && $stable(rsp_rf_level))
      else $error("result changed while stalled");

   // Reset empties the result register
   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Input backpressure only comes from a stalled full result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !reset && req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

   // A result appearing from empty comes from a request that passed through the input register
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching request");

endmodule

bind framed_name_beacon_modulator_core fnbm_checker u_fnbm_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_af_level     (rsp_af_level),
   .rsp_rf_level     (rsp_rf_level)
);
